// File: rtl/nmhc_pkg.sv
// shared types, constants and the crc-32c byte update for the health response checker
package nmhc_pkg;

  // message layout
  localparam int unsigned HEADER_BYTES    = 8;
  localparam int unsigned TYPE_MASK_BITS  = 7;
  localparam int unsigned FLAG_TYPE_SHIFT = 3;
  localparam int unsigned FLAG_TYPE_BITS  = 4;
  localparam int unsigned TRAILER_BYTES   = 4;
  localparam int unsigned MIN_LENGTH      = HEADER_BYTES + TRAILER_BYTES;
  localparam int unsigned STATUS_POS      = 4;
  localparam int unsigned FLAGS_POS       = 1;
  localparam int unsigned TEMP_POS        = HEADER_BYTES + 5;

  localparam logic [7:0] TYPE_MASK = 8'((1 << TYPE_MASK_BITS) - 1);
  localparam logic [7:0] FLAG_MASK = 8'((1 << FLAG_TYPE_BITS) - 1);

  localparam logic [7:0] TEMP_NO_DATA   = 8'h80;
  localparam logic [7:0] TEMP_SENSOR_ERR = 8'h81;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_TYPE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SUCCESS_STATUS  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PENDING_STATUS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MI_COMMAND_KIND = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_POLL_LENGTH = 3'd4;

  typedef enum logic [3:0] {
    OUT_VALID      = 4'd0,
    OUT_UNAVAIL    = 4'd1,
    OUT_BAD_TYPE   = 4'd2,
    OUT_SHORT      = 4'd3,
    OUT_CRC        = 4'd4,
    OUT_PENDING    = 4'd5,
    OUT_FAILED     = 4'd6,
    OUT_NOT_MI     = 4'd7,
    OUT_POLL_SHORT = 4'd8
  } outcome_t;

  typedef struct packed {
    logic [6:0] expected_type;
    logic [7:0] success_status;
    logic [7:0] pending_status;
    logic [3:0] mi_command_kind;
    logic [7:0] min_poll_length;
  } cfg_t;

  typedef struct packed {
    logic       step;
    logic [7:0] data_byte;
    logic       last;
  } beat_t;

  typedef struct packed {
    outcome_t           outcome;
    logic signed [7:0]  temperature;
  } result_t;

  // reflected crc-32c, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/nvme_mi_health_response_checker_unit.sv
// top level of the management health response checker with crc-32c trailer check
//
// usage:
//   s_axis carries the response one byte per beat, tlast on the final byte.
//   m_axis gives one result beat per message, on its last byte only:
//   outcome in tdata[3:0], signed temperature in tdata[11:4] (zero unless
//   the outcome is valid).
//   cfg_we/cfg_index/cfg_data write the five registers; write only while idle.
// throughput and pipeline:
//   one byte per cycle sustained while results are taken. a byte is held in
//   the input register, then the crc update, header capture and verdict run
//   in one pass into the result register, where the result of a last byte
//   shows. the single-byte crc step sets the cycle time.
// reset:
//   rst (synchronous) restores the register defaults, empties both stages and
//   clears the message state.
// stall:
//   while m_axis_tready is low with a result waiting, an empty input register
//   still takes one more beat, then s_axis_tready drops until the result is taken.
module nvme_mi_health_response_checker_unit #(
  parameter int unsigned COUNT_MAX = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,   // [3:0] outcome, [11:4] temperature
  input  logic                              cfg_we,
  input  logic [nmhc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [7:0]                        cfg_data
);
  import nmhc_pkg::*;

  cfg_t       cfg;
  beat_t      beat;
  result_t    result;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  result_t    out_result;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  assign beat.step      = in_valid && advance;
  assign beat.data_byte = in_byte;
  assign beat.last      = in_last;

  nmhc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  nmhc_msg_track #(.COUNT_MAX(COUNT_MAX)) u_track (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .beat   (beat),
    .result (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid && in_last;
    end
    if (beat.step && in_last) begin
      out_result <= result;
    end
  end

  assign m_axis_tdata = {4'd0, out_result.temperature, out_result.outcome};

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_valid && in_last))
    else $error("result appeared without a last byte");

  a_temp_only_valid: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_result.temperature != 8'sd0) |-> out_result.outcome == OUT_VALID)
    else $error("temperature reported with a non-valid outcome");

  a_stall_needs_data: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

  a_outcome_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_result.outcome <= OUT_POLL_SHORT))
    else $error("outcome code out of range");

endmodule

// File: rtl/nmhc_cfg_regs.sv
// configuration register file for the health response checker
module nmhc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [nmhc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [7:0]                         cfg_data,
  output nmhc_pkg::cfg_t                     cfg
);
  import nmhc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_type   <= 7'd4;
      cfg.success_status  <= 8'd0;
      cfg.pending_status  <= 8'd4;
      cfg.mi_command_kind <= 4'd1;
      cfg.min_poll_length <= 8'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPECTED_TYPE:   cfg.expected_type   <= cfg_data[6:0];
        CFG_SUCCESS_STATUS:  cfg.success_status  <= cfg_data;
        CFG_PENDING_STATUS:  cfg.pending_status  <= cfg_data;
        CFG_MI_COMMAND_KIND: cfg.mi_command_kind <= cfg_data[3:0];
        CFG_MIN_POLL_LENGTH: cfg.min_poll_length <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/nmhc_msg_track.sv
// per-message state: trailer delay, running crc, byte count, header capture and verdict
module nmhc_msg_track #(
  parameter int unsigned COUNT_MAX = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  nmhc_pkg::cfg_t    cfg,
  input  nmhc_pkg::beat_t   beat,
  output nmhc_pkg::result_t result
);
  import nmhc_pkg::*;

  localparam int unsigned CNT_W = $clog2(COUNT_MAX + 1);

  logic [31:0]      trailer_delay, trailer_delay_next;
  logic [31:0]      crc_acc, crc_acc_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       type_byte, type_byte_next;
  logic [7:0]       flags_byte, flags_byte_next;
  logic [7:0]       status_byte, status_byte_next;
  logic [7:0]       temp_byte, temp_byte_next;
  logic [31:0]      pos, len;

  always_comb begin
    pos = {{(32-CNT_W){1'b0}}, byte_count};

    // oldest byte of the delay joins the crc once four bytes are held
    crc_acc_next       = (pos >= TRAILER_BYTES) ? crc_byte(crc_acc, trailer_delay[7:0]) : crc_acc;
    trailer_delay_next = {beat.data_byte, trailer_delay[31:8]};

    type_byte_next   = (pos == 32'd0)       ? beat.data_byte : type_byte;
    flags_byte_next  = (pos == FLAGS_POS)   ? beat.data_byte : flags_byte;
    status_byte_next = (pos == STATUS_POS)  ? beat.data_byte : status_byte;
    temp_byte_next   = (pos == TEMP_POS)    ? beat.data_byte : temp_byte;

    byte_count_next = (byte_count < CNT_W'(COUNT_MAX)) ? byte_count + 1'b1 : byte_count;
    len = {{(32-CNT_W){1'b0}}, byte_count_next};

    result.temperature = 8'sd0;
    priority if ((type_byte_next & TYPE_MASK) != {1'b0, cfg.expected_type}) begin
      result.outcome = OUT_BAD_TYPE;
    end else if (len < MIN_LENGTH) begin
      result.outcome = OUT_SHORT;
    end else if (trailer_delay_next != ~crc_acc_next) begin
      result.outcome = OUT_CRC;
    end else if (status_byte_next == cfg.pending_status) begin
      result.outcome = OUT_PENDING;
    end else if (status_byte_next != cfg.success_status) begin
      result.outcome = OUT_FAILED;
    end else if (((flags_byte_next >> FLAG_TYPE_SHIFT) & FLAG_MASK) !=
                 {4'd0, cfg.mi_command_kind}) begin
      result.outcome = OUT_NOT_MI;
    end else if (len < MIN_LENGTH + {24'd0, cfg.min_poll_length}) begin
      result.outcome = OUT_POLL_SHORT;
    end else if (temp_byte_next == TEMP_NO_DATA || temp_byte_next == TEMP_SENSOR_ERR) begin
      result.outcome = OUT_UNAVAIL;
    end else begin
      result.outcome     = OUT_VALID;
      result.temperature = temp_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (beat.step && beat.last)) begin
      trailer_delay <= 32'd0;
      crc_acc       <= CRC_INIT;
      byte_count    <= '0;
      type_byte     <= 8'd0;
      flags_byte    <= 8'd0;
      status_byte   <= 8'd0;
      temp_byte     <= 8'd0;
    end else if (beat.step) begin
      trailer_delay <= trailer_delay_next;
      crc_acc       <= crc_acc_next;
      byte_count    <= byte_count_next;
      type_byte     <= type_byte_next;
      flags_byte    <= flags_byte_next;
      status_byte   <= status_byte_next;
      temp_byte     <= temp_byte_next;
    end
  end

endmodule
